// ----- rtl/core/sn2d_pkg.sv -----
// shared types and constants of the 2d simplex noise evaluator
package sn2d_pkg;

    localparam int COORD_FRAC = 16;
    localparam int INNER_FRAC = 24;
    localparam int SKEW_FRAC  = COORD_FRAC + 30;
    localparam int SKEW_W     = SKEW_FRAC + 8;
    localparam int OUT_SHIFT  = INNER_FRAC - 14;
    localparam int N_RD       = 5;

    localparam logic        CMD_WRITE   = 1'b1;
    localparam logic [28:0] F2_Q30      = 29'd393016784;
    localparam logic [29:0] G2_Q32      = 30'd907633384;
    localparam logic [23:0] G2_FX       = 24'd3545443;
    localparam logic [23:0] RSQ2_FX     = 24'd11863283;
    localparam logic [23:0] FX_HALF     = 24'd8388608;
    localparam logic [6:0]  NOISE_SCALE = 7'd70;
    localparam logic [7:0]  SEED_MULT   = 8'd245;
    localparam logic [15:0] NOISE_MAX   = 16'd16384;

    typedef enum logic [2:0] {
        GRAD_PP = 3'd0,
        GRAD_MP = 3'd1,
        GRAD_PM = 3'd2,
        GRAD_NN = 3'd3,
        GRAD_XP = 3'd4,
        GRAD_XN = 3'd5,
        GRAD_YP = 3'd6,
        GRAD_YN = 3'd7
    } t_grad;

    typedef struct packed {
        logic               is_wr;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [7:0]         seed_off;
        logic [7:0]         idx;
        logic [7:0]         val;
    } t_item;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } t_tbl_wr;

endpackage

// ----- rtl/core/sn2d_in_if.sv -----
// input channel of the noise evaluator
interface sn2d_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic [7:0]         seed;
    logic [7:0]         table_index;
    logic [7:0]         table_value;

    modport source (output valid, cmd, x_coord, y_coord, seed, table_index, table_value,
                    input ready);
    modport sink (input valid, cmd, x_coord, y_coord, seed, table_index, table_value,
                  output ready);
endinterface

// ----- rtl/core/sn2d_out_if.sv -----
// result channel of the noise evaluator
interface sn2d_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink (input valid, noise_value, output ready);
endinterface

// ----- rtl/core/sn2d_ram.sv -----
// generic single write port ram with registered read
module sn2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/sn2d_front.sv -----
// front end: accepts items, decodes them and queues them for the back end
module sn2d_front #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sn2d_in_if.sink             i_in,
    output sn2d_pkg::t_item     o_head,
    output logic                o_head_vld,
    input  logic                i_pop
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    sn2d_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr, r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            push, pop;
    logic [15:0]     seed_prod;
    sn2d_pkg::t_item new_item;

    assign i_in.ready = (r_cnt != CW'(DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_pop && (r_cnt != '0);

    // seed enters the hash as seed * 1013, only the low byte matters
    assign seed_prod = {8'd0, i_in.seed} * {8'd0, sn2d_pkg::SEED_MULT};

    always_comb begin
        new_item.is_wr    = (i_in.cmd == sn2d_pkg::CMD_WRITE);
        new_item.x        = i_in.x_coord;
        new_item.y        = i_in.y_coord;
        new_item.seed_off = seed_prod[7:0];
        new_item.idx      = i_in.table_index;
        new_item.val      = i_in.table_value;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= new_item;
        end
    end

    assign o_head     = r_mem[r_rd_ptr];
    assign o_head_vld = (r_cnt != '0);
endmodule

// ----- rtl/core/sn2d_tbl.sv -----
// permutation table: five read copies, identity until an entry is written
module sn2d_tbl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sn2d_pkg::t_tbl_wr                   i_wr,
    input  logic                                i_rd_en,
    input  logic [sn2d_pkg::N_RD-1:0][7:0]      i_rd_addr,
    output logic [sn2d_pkg::N_RD-1:0][7:0]      o_rd_data
);
    logic [255:0]                      r_valid;
    logic [sn2d_pkg::N_RD-1:0]         r_rd_vld;
    logic [sn2d_pkg::N_RD-1:0][7:0]    r_rd_addr;
    logic [sn2d_pkg::N_RD-1:0][7:0]    ram_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    for (genvar k = 0; k < sn2d_pkg::N_RD; k++) begin : g_copy
        always_ff @(posedge i_clk) begin
            if (i_rd_en) begin
                r_rd_vld[k]  <= r_valid[i_rd_addr[k]];
                r_rd_addr[k] <= i_rd_addr[k];
            end
        end

        sn2d_ram #(.WIDTH(8), .DEPTH(256)) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_wr.en),
            .i_waddr (i_wr.addr),
            .i_wdata (i_wr.data),
            .i_re    (i_rd_en),
            .i_raddr (i_rd_addr[k]),
            .o_rdata (ram_q[k])
        );

        // unwritten entry k holds k
        assign o_rd_data[k] = r_rd_vld[k] ? ram_q[k] : r_rd_addr[k];
    end
endmodule

// ----- rtl/core/sn2d_corner.sv -----
// one corner contribution: falloff^4 times gradient dot, six stages
module sn2d_corner (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [26:0] i_dx,
    input  logic signed [26:0] i_dy,
    input  sn2d_pkg::t_grad    i_gi,
    output logic [21:0]        o_mag,
    output logic               o_neg
);
    // stage 1
    logic [26:0]        ax_c, ay_c;
    logic signed [27:0] sx, sy, s_c;
    logic               far_c, diag_c;
    logic [23:0]        r1_ax, r1_ay;
    logic signed [27:0] r1_s;
    logic               r1_far, r1_diag;
    // stage 2
    logic [27:0]        smag;
    logic [49:0]        diag_prod;
    logic [47:0]        sqx_prod, sqy_prod;
    logic [23:0]        r2_sqx, r2_sqy;
    logic [25:0]        r2_dot;
    logic               r2_neg, r2_far;
    // stage 3
    logic [24:0]        sq;
    logic [23:0]        r3_t;
    logic [25:0]        r3_dot;
    logic               r3_neg, r3_zero;
    // stages 4 to 6
    logic [47:0]        t2_prod, t4_prod;
    logic [49:0]        m_prod;
    logic [23:0]        r4_t2, r5_t4;
    logic [25:0]        r4_dot, r5_dot;
    logic               r4_neg, r4_zero, r5_neg, r5_zero;
    logic [21:0]        r6_mag;
    logic               r6_neg;

    assign ax_c   = i_dx[26] ? -i_dx : i_dx;
    assign ay_c   = i_dy[26] ? -i_dy : i_dy;
    assign far_c  = (|ax_c[26:24]) || (|ay_c[26:24]);
    assign sx     = 28'(i_dx);
    assign sy     = 28'(i_dy);
    assign diag_c = (i_gi == sn2d_pkg::GRAD_PP) || (i_gi == sn2d_pkg::GRAD_MP) ||
                    (i_gi == sn2d_pkg::GRAD_PM) || (i_gi == sn2d_pkg::GRAD_NN);

    always_comb begin
        case (i_gi)
            sn2d_pkg::GRAD_PP: s_c = sx + sy;
            sn2d_pkg::GRAD_MP: s_c = sy - sx;
            sn2d_pkg::GRAD_PM: s_c = sx - sy;
            sn2d_pkg::GRAD_NN: s_c = -sx - sy;
            sn2d_pkg::GRAD_XP: s_c = sx;
            sn2d_pkg::GRAD_XN: s_c = -sx;
            sn2d_pkg::GRAD_YP: s_c = sy;
            default:           s_c = -sy;
        endcase
    end

    assign smag      = r1_s[27] ? -r1_s : r1_s;
    assign diag_prod = smag[25:0] * sn2d_pkg::RSQ2_FX;
    assign sqx_prod  = r1_ax * r1_ax;
    assign sqy_prod  = r1_ay * r1_ay;

    assign sq = {1'b0, r2_sqx} + {1'b0, r2_sqy};

    assign t2_prod = r3_t * r3_t;
    assign t4_prod = r4_t2 * r4_t2;
    assign m_prod  = r5_t4 * r5_dot;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax   <= ax_c[23:0];
            r1_ay   <= ay_c[23:0];
            r1_s    <= s_c;
            r1_far  <= far_c;
            r1_diag <= diag_c;

            r2_sqx  <= sqx_prod[47:24];
            r2_sqy  <= sqy_prod[47:24];
            r2_dot  <= r1_diag ? diag_prod[49:24] : smag[25:0];
            r2_neg  <= r1_s[27];
            r2_far  <= r1_far;

            // falloff below zero gives nothing
            r3_zero <= r2_far || (sq > {1'b0, sn2d_pkg::FX_HALF});
            r3_t    <= sn2d_pkg::FX_HALF - sq[23:0];
            r3_dot  <= r2_dot;
            r3_neg  <= r2_neg;

            r4_t2   <= t2_prod[47:24];
            r4_dot  <= r3_dot;
            r4_neg  <= r3_neg;
            r4_zero <= r3_zero;

            r5_t4   <= t4_prod[47:24];
            r5_dot  <= r4_dot;
            r5_neg  <= r4_neg;
            r5_zero <= r4_zero;

            r6_mag  <= r5_zero ? '0 : m_prod[45:24];
            r6_neg  <= r5_neg;
        end
    end

    assign o_mag = r6_mag;
    assign o_neg = r6_neg;
endmodule

// ----- rtl/core/sn2d_back.sv -----
// back end: skew, table hashing, three corners, scaling and output register
module sn2d_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sn2d_pkg::t_item                i_head,
    input  logic                           i_head_vld,
    output logic                           o_pop,
    output sn2d_pkg::t_tbl_wr              o_tbl_wr,
    output logic                           o_rd_en,
    output logic [sn2d_pkg::N_RD-1:0][7:0] o_rd_addr,
    input  logic [sn2d_pkg::N_RD-1:0][7:0] i_rd_data,
    sn2d_out_if.source                     o_out
);
    localparam int NSTG = 13;
    localparam int XW   = sn2d_pkg::SKEW_W - 30;

    logic [NSTG-1:0] r_vld;
    logic            en, drain_ok, wr_go, take_eval;

    // stage 1
    logic signed [32:0] s_sum;
    logic signed [62:0] skew_prod;
    logic [sn2d_pkg::SKEW_W-1:0] r1_p;
    logic [XW-1:0]      r1_x, r1_y;
    logic [7:0]         r1_soff;
    // stage 2
    logic [sn2d_pkg::SKEW_W-1:0] u_c, v_c;
    logic [23:0]        r2_fu, r2_fv;
    logic [7:0]         r2_ii, r2_jj;
    // stage 3
    logic [24:0]        f_sum;
    logic [54:0]        g_prod;
    logic [23:0]        r3_fu, r3_fv;
    logic [22:0]        r3_g;
    logic [7:0]         r3_ii;
    logic signed [25:0] x0_c, y0_c;
    logic               i1_c;
    // stage 4
    logic signed [25:0] r4_x0, r4_y0;
    logic               r4_i1;
    logic signed [26:0] dx0, dy0, ofs_one, g2s, g2s2;
    // stage 5
    logic signed [26:0] r5_dx [3];
    logic signed [26:0] r5_dy [3];
    sn2d_pkg::t_grad    r5_gi [3];
    // corner results, sum and scaling
    logic [21:0]        c_mag [3];
    logic               c_neg [3];
    logic signed [22:0] contrib [3];
    logic signed [24:0] total;
    logic [23:0]        r11_mag;
    logic               r11_neg;
    logic [30:0]        scaled;
    logic [20:0]        sc;
    logic [15:0]        sat;
    logic [15:0]        r12_out;

    assign en        = !r_vld[NSTG-1] || o_out.ready;
    // table writes wait until no item ahead of the hash reads is in flight
    assign drain_ok  = !(|r_vld[2:0]);
    assign wr_go     = i_head_vld && i_head.is_wr && drain_ok;
    assign take_eval = en && i_head_vld && !i_head.is_wr;
    assign o_pop     = wr_go || take_eval;

    always_comb begin
        o_tbl_wr.en   = wr_go;
        o_tbl_wr.addr = i_head.idx;
        o_tbl_wr.data = i_head.val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], take_eval};
        end
    end

    // skew: u = x + (x+y)*F2, the product is shared by both axes
    assign s_sum     = $signed({i_head.x[31], i_head.x}) + $signed({i_head.y[31], i_head.y});
    assign skew_prod = s_sum * $signed({1'b0, sn2d_pkg::F2_Q30});

    assign u_c = {r1_x, 30'd0} + r1_p;
    assign v_c = {r1_y, 30'd0} + r1_p;

    assign f_sum  = {1'b0, r2_fu} + {1'b0, r2_fv};
    assign g_prod = f_sum * sn2d_pkg::G2_Q32;

    assign x0_c = $signed({2'b00, r3_fu}) - $signed({3'b000, r3_g});
    assign y0_c = $signed({2'b00, r3_fv}) - $signed({3'b000, r3_g});
    assign i1_c = (x0_c > y0_c);

    assign o_rd_en      = en;
    assign o_rd_addr[0] = r2_jj;
    assign o_rd_addr[1] = r2_jj + 8'd1;
    assign o_rd_addr[2] = r3_ii + i_rd_data[0];
    assign o_rd_addr[3] = r3_ii + {7'd0, i1_c} + (i1_c ? i_rd_data[0] : i_rd_data[1]);
    assign o_rd_addr[4] = r3_ii + 8'd1 + i_rd_data[1];

    assign dx0     = 27'(r4_x0);
    assign dy0     = 27'(r4_y0);
    assign ofs_one = 27'sd16777216;
    assign g2s     = $signed({3'b000, sn2d_pkg::G2_FX});
    assign g2s2    = $signed({2'b00, sn2d_pkg::G2_FX, 1'b0});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p    <= skew_prod[sn2d_pkg::SKEW_W-1:0];
            r1_x    <= i_head.x[XW-1:0];
            r1_y    <= i_head.y[XW-1:0];
            r1_soff <= i_head.seed_off;

            r2_fu <= u_c[sn2d_pkg::SKEW_FRAC-1 -: sn2d_pkg::INNER_FRAC];
            r2_fv <= v_c[sn2d_pkg::SKEW_FRAC-1 -: sn2d_pkg::INNER_FRAC];
            r2_ii <= u_c[sn2d_pkg::SKEW_W-1 -: 8] + r1_soff;
            r2_jj <= v_c[sn2d_pkg::SKEW_W-1 -: 8];

            r3_fu <= r2_fu;
            r3_fv <= r2_fv;
            r3_g  <= g_prod[54:32];
            r3_ii <= r2_ii;

            r4_x0 <= x0_c;
            r4_y0 <= y0_c;
            r4_i1 <= i1_c;

            r5_dx[0] <= dx0;
            r5_dy[0] <= dy0;
            r5_dx[1] <= dx0 - (r4_i1 ? ofs_one : 27'sd0) + g2s;
            r5_dy[1] <= dy0 - (r4_i1 ? 27'sd0 : ofs_one) + g2s;
            r5_dx[2] <= dx0 - ofs_one + g2s2;
            r5_dy[2] <= dy0 - ofs_one + g2s2;
            r5_gi[0] <= sn2d_pkg::t_grad'(i_rd_data[2][2:0]);
            r5_gi[1] <= sn2d_pkg::t_grad'(i_rd_data[3][2:0]);
            r5_gi[2] <= sn2d_pkg::t_grad'(i_rd_data[4][2:0]);

            r11_mag <= total[24] ? 24'(-total) : total[23:0];
            r11_neg <= total[24];

            r12_out <= r11_neg ? -sat : sat;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_corner
        sn2d_corner u_corner (
            .i_clk (i_clk),
            .i_en  (en),
            .i_dx  (r5_dx[k]),
            .i_dy  (r5_dy[k]),
            .i_gi  (r5_gi[k]),
            .o_mag (c_mag[k]),
            .o_neg (c_neg[k])
        );
        assign contrib[k] = c_neg[k] ? -$signed({1'b0, c_mag[k]}) : $signed({1'b0, c_mag[k]});
    end

    assign total  = 25'(contrib[0]) + 25'(contrib[1]) + 25'(contrib[2]);
    assign scaled = r11_mag * sn2d_pkg::NOISE_SCALE;
    assign sc     = scaled[sn2d_pkg::OUT_SHIFT + 20 : sn2d_pkg::OUT_SHIFT];
    assign sat    = (sc > {5'd0, sn2d_pkg::NOISE_MAX}) ? sn2d_pkg::NOISE_MAX : sc[15:0];

    assign o_out.valid       = r_vld[NSTG-1];
    assign o_out.noise_value = r12_out;
endmodule

// ----- rtl/core/simplex_noise_2d_eval.sv -----
// 2d simplex noise evaluator, top level
//
// i_in carries one item per valid/ready handshake. cmd = write stores
// table_value at table_index of the 256-byte permutation table and gives no
// result; cmd = evaluate takes a Q16.16 point and a seed and gives one
// Q2.14 noise value on o_out, in the order the items came in.
// Items enter a small queue (QUEUE_DEPTH entries); i_in.ready falls only when
// it is full. The evaluation pipeline takes one point per cycle while o_out is
// not stalled, so a steady stream of points runs at one item per cycle. Items
// pass through the queue and then the 13 pipeline stages, whose depth is set
// by the two dependent table reads and the four chained products of a
// corner.
// A table write waits until no earlier point still has table reads ahead of
// it, then is written to the table as it leaves the queue.
// When o_out.valid is high and o_out.ready is low the whole pipeline holds
// and the queue fills.
// Reset empties queue and pipeline and returns the table to identity
// (entry k holds k) at once, with no clearing pass.
module simplex_noise_2d_eval #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sn2d_in_if.sink    i_in,
    sn2d_out_if.source o_out
);
    sn2d_pkg::t_item                head;
    logic                           head_vld;
    logic                           pop;
    sn2d_pkg::t_tbl_wr              tbl_wr;
    logic                           rd_en;
    logic [sn2d_pkg::N_RD-1:0][7:0] rd_addr;
    logic [sn2d_pkg::N_RD-1:0][7:0] rd_data;

    sn2d_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_head     (head),
        .o_head_vld (head_vld),
        .i_pop      (pop)
    );

    sn2d_tbl u_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sn2d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_head_vld (head_vld),
        .o_pop      (pop),
        .o_tbl_wr   (tbl_wr),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_out      (o_out)
    );

    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head_vld)
        else $error("queue popped while empty");

    a_wr_is_write_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_wr.en |-> (pop && head.is_wr))
        else $error("table written without a write item at the queue head");

    a_write_item_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && head.is_wr) |-> tbl_wr.en)
        else $error("write item left the queue without a table write");

    a_noise_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.noise_value <= 16'sd16384) &&
                         (o_out.noise_value >= -16'sd16384)))
        else $error("noise value outside saturation range");
endmodule

// ----- test/tb_top.sv -----
// testbench for the 2d simplex noise evaluator: predicted noise values checked in order
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 800;

    // expected noise values and a private copy of the permutation table
    class noise_scoreboard;
        logic [7:0]         perm [256];
        logic signed [15:0] noise_q [$];
        int                 errors;

        function new();
            for (int k = 0; k < 256; k++) begin
                perm[k] = k[7:0];
            end
            errors = 0;
        endfunction

        // floor(a*b / 2^24) on magnitudes
        function automatic longint unsigned fx_product(longint unsigned a, longint unsigned b);
            bit [127:0] p;
            p = a * b;
            return longint'(p >> sn2d_pkg::INNER_FRAC);
        endfunction

        function automatic longint with_sign(longint unsigned m, bit neg);
            return neg ? -longint'(m) : longint'(m);
        endfunction

        function automatic longint unsigned magnitude(longint v);
            return v < 0 ? longint'(-v) : longint'(v);
        endfunction

        // one corner's contribution in Q.24
        function automatic longint corner_term(longint dx, longint dy, sn2d_pkg::t_grad gi);
            longint unsigned ax, ay, sq, t, t2, t4;
            longint unsigned one, half, rsq;
            longint          s, dot;
            one  = 64'd1 << sn2d_pkg::INNER_FRAC;
            half = 64'd1 << (sn2d_pkg::INNER_FRAC - 1);
            rsq  = (64'd3037000499 + 64'd128) >> 8;
            ax = magnitude(dx);
            ay = magnitude(dy);
            if (ax >= one || ay >= one) return 0;
            sq = fx_product(ax, ax) + fx_product(ay, ay);
            if (sq > half) return 0;
            t  = half - sq;
            t2 = fx_product(t, t);
            t4 = fx_product(t2, t2);
            s  = 0;
            case (gi)
                sn2d_pkg::GRAD_PP: s = dx + dy;
                sn2d_pkg::GRAD_MP: s = dy - dx;
                sn2d_pkg::GRAD_PM: s = dx - dy;
                sn2d_pkg::GRAD_NN: s = -dx - dy;
                default: s = 0;
            endcase
            case (gi)
                sn2d_pkg::GRAD_XP: dot = dx;
                sn2d_pkg::GRAD_XN: dot = -dx;
                sn2d_pkg::GRAD_YP: dot = dy;
                sn2d_pkg::GRAD_YN: dot = -dy;
                default: dot = with_sign(fx_product(magnitude(s), rsq), s < 0);
            endcase
            return with_sign(fx_product(t4, magnitude(dot)), dot < 0);
        endfunction

        function automatic logic signed [15:0] noise_at(logic signed [31:0] x,
                                                         logic signed [31:0] y,
                                                         logic [7:0] seed);
            longint unsigned xs, ys, u, v, fmask, fu, fv, g, g2f, one, mag;
            longint          x0, y0, x1, y1, x2, y2, total;
            int unsigned     ii, jj, i1, j1, h0, h1, h2;
            xs = longint'(x);
            ys = longint'(y);
            u = (xs << 30) + (xs + ys) * 64'd393016784;
            v = (ys << 30) + (xs + ys) * 64'd393016784;
            fmask = (64'd1 << sn2d_pkg::SKEW_FRAC) - 1;
            fu = (u & fmask) >> (sn2d_pkg::SKEW_FRAC - sn2d_pkg::INNER_FRAC);
            fv = (v & fmask) >> (sn2d_pkg::SKEW_FRAC - sn2d_pkg::INNER_FRAC);
            g  = ((fu + fv) * 64'd907633384) >> 32;
            x0 = longint'(fu) - longint'(g);
            y0 = longint'(fv) - longint'(g);
            if (x0 > y0) begin
                i1 = 1; j1 = 0;
            end else begin
                i1 = 0; j1 = 1;
            end
            one = 64'd1 << sn2d_pkg::INNER_FRAC;
            g2f = (64'd907633384 + 64'd128) >> 8;
            x1 = x0 - (i1 ? longint'(one) : 0) + longint'(g2f);
            y1 = y0 - (j1 ? longint'(one) : 0) + longint'(g2f);
            x2 = x0 - longint'(one) + 2 * longint'(g2f);
            y2 = y0 - longint'(one) + 2 * longint'(g2f);
            // seed is mixed into the x cell index
            ii = int'(((u >> sn2d_pkg::SKEW_FRAC) + longint'(seed) * 1013) & 255);
            jj = int'((v >> sn2d_pkg::SKEW_FRAC) & 255);
            h0 = perm[(ii + perm[jj]) & 255] & 7;
            h1 = perm[(ii + i1 + perm[(jj + j1) & 255]) & 255] & 7;
            h2 = perm[(ii + 1 + perm[(jj + 1) & 255]) & 255] & 7;
            total = corner_term(x0, y0, sn2d_pkg::t_grad'(h0[2:0]))
                  + corner_term(x1, y1, sn2d_pkg::t_grad'(h1[2:0]))
                  + corner_term(x2, y2, sn2d_pkg::t_grad'(h2[2:0]));
            mag = (magnitude(total) * 70) >> sn2d_pkg::OUT_SHIFT;
            if (mag > 16384) mag = 16384;
            return 16'(with_sign(mag, total < 0));
        endfunction

        function void note_input(logic cmd, logic signed [31:0] x, logic signed [31:0] y,
                                 logic [7:0] seed, logic [7:0] idx, logic [7:0] val);
            if (cmd == sn2d_pkg::CMD_WRITE) perm[idx] = val;
            else noise_q.push_back(noise_at(x, y, seed));
        endfunction

        function void check_result(logic signed [15:0] actual);
            logic signed [15:0] exp_val;
            if (noise_q.size() == 0) begin
                $display("%0t: unexpected noise value %0d", $time, actual);
                errors++;
                return;
            end
            exp_val = noise_q.pop_front();
            if (actual !== exp_val) begin
                $display("%0t: noise_value mismatch: expected %0d, actual %0d",
                         $time, exp_val, actual);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   idle_cycles = 0;
    noise_scoreboard sb;

    sn2d_in_if  in_ch ();
    sn2d_out_if out_ch ();

    simplex_noise_2d_eval u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic cmd, logic signed [31:0] x, logic signed [31:0] y,
                             logic [7:0] seed, logic [7:0] idx, logic [7:0] val);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.x_coord     <= x;
        in_ch.y_coord     <= y;
        in_ch.seed        <= seed;
        in_ch.table_index <= idx;
        in_ch.table_value <= val;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(cmd, x, y, seed, idx, val);
        @(negedge i_clk);
    endtask

    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, logic [7:0] seed);
        send_item(~sn2d_pkg::CMD_WRITE, x, y, seed, 8'($urandom), 8'($urandom));
    endtask

    // result side: random stalls driven at the falling edge
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = gap_len();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.noise_value);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int r;
        logic signed [31:0] x, y;
        sb = new();
        in_ch.valid = 1'b0;
        in_ch.cmd = ~sn2d_pkg::CMD_WRITE;
        in_ch.x_coord = '0;
        in_ch.y_coord = '0;
        in_ch.seed = '0;
        in_ch.table_index = '0;
        in_ch.table_value = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: coordinate extremes, seeds, table writes at the ends
        send_point(32'sd0, 32'sd0, 8'd0);
        send_point(32'sh7fffffff, 32'sh7fffffff, 8'd255);
        send_point(32'sh80000000, 32'sh80000000, 8'd0);
        send_point(32'sh7fffffff, 32'sh80000000, 8'd1);
        send_point(32'sh80000000, 32'sh7fffffff, 8'd128);
        send_point(32'sd32768, 32'sd0, 8'd0);
        send_point(32'sd0, 32'sd32768, 8'd0);
        send_point(-32'sd19000, 32'sd21000, 8'd7);
        send_point(32'sd5000, -32'sd5000, 8'd3);
        send_point(32'sd200000, 32'sd100000, 8'd255);
        send_point(32'sd65536, 32'sd65536, 8'd0);
        send_point(-32'sd1, -32'sd1, 8'd0);
        send_item(sn2d_pkg::CMD_WRITE, 0, 0, 8'd0, 8'd0, 8'd255);
        send_item(sn2d_pkg::CMD_WRITE, 0, 0, 8'd0, 8'd255, 8'd0);
        send_item(sn2d_pkg::CMD_WRITE, 0, 0, 8'd0, 8'd1, 8'd170);
        send_point(32'sd0, 32'sd0, 8'd0);
        send_point(-32'sd40000, -32'sd70000, 8'd0);
        send_point(32'sd1000, 32'sd30000, 8'd255);
        for (int k = 0; k < 6; k++) begin
            send_point(32'sd12000 * k, 32'sd9000 * (3 - k), 8'(k * 40));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                send_item(sn2d_pkg::CMD_WRITE, 32'($urandom), 32'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom));
            end else begin
                if (r < 45) begin
                    x = 32'($urandom);
                    y = 32'($urandom);
                end else begin
                    // near the origin, a few cells across
                    x = $signed(32'($urandom_range(0, 32'h7ffff))) - 32'sh40000;
                    y = $signed(32'($urandom_range(0, 32'h7ffff))) - 32'sh40000;
                end
                send_point(x, y, 8'($urandom));
            end
        end
        in_ch.valid <= 1'b0;

        while (sb.noise_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
